/* rtl/md4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and tables of the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
    localparam logic [31:0] PAD_WORD = 32'h00000080;
    localparam logic [2:0] FULL_COUNT = 3'd4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        end_of_message;
    } t_item;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_COMP,
        ST_EXTRA,
        ST_PAD,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_OUT
    } t_state;

    function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] st);
        logic [3:0] r;
        begin
            case (rnd)
                2'd0: r = st;
                2'd1: r = {st[1:0], st[3:2]};
                default: r = {st[0], st[1], st[2], st[3]};
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] st);
        logic [4:0] r;
        begin
            case ({rnd, st})
                4'b0000: r = 5'd3;
                4'b0001: r = 5'd7;
                4'b0010: r = 5'd11;
                4'b0011: r = 5'd19;
                4'b0100: r = 5'd3;
                4'b0101: r = 5'd5;
                4'b0110: r = 5'd9;
                4'b0111: r = 5'd13;
                4'b1000: r = 5'd3;
                4'b1001: r = 5'd9;
                4'b1010: r = 5'd11;
                default: r = 5'd15;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/md4_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_front
// Input stage and item queue: takes message words and holds them for the core.
// ----------------------------------------------------------------------------
module md4_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  md4_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output md4_pkg::t_item  o_item
);
    import md4_pkg::*;

    t_item           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] r_wr, r_rd;
    logic            push, pop;
    t_item           norm;

    always_comb begin
        norm = i_item;
        if (!i_item.end_of_message || i_item.byte_count > FULL_COUNT) begin
            norm.byte_count = FULL_COUNT;
        end
    end

    assign o_ready = (r_wr - r_rd) != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_valid = r_wr != r_rd;
    assign o_item  = r_mem[r_rd[QUEUE_AW-1:0]];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr[QUEUE_AW-1:0]] <= norm;
    end
endmodule

/* rtl/md4_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_core
// Block buffer, padding sequencer and one-step-per-cycle compression.
// ----------------------------------------------------------------------------
module md4_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  md4_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_digest_a,
    output logic [31:0]     o_digest_b,
    output logic [31:0]     o_digest_c,
    output logic [31:0]     o_digest_d
);
    import md4_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_buf [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_step;
    t_state      r_ret, n_ret;

    logic        wr_en;
    logic [31:0] wr_data;
    logic        start;
    logic [31:0] mask, fval, sum, rot;
    logic [1:0]  rnd;
    logic [4:0]  sh;
    logic [1:0]  bc;

    assign rnd = r_step[5:4];
    assign sh  = rot_amount(rnd, r_step[1:0]);
    assign bc  = i_item.byte_count[1:0];

    always_comb begin
        case (rnd)
            2'd0: fval = (r_b & r_c) | (~r_b & r_d);
            2'd1: fval = ((r_b & r_c) | (r_b & r_d) | (r_c & r_d)) + K_ROUND2;
            default: fval = (r_b ^ r_c ^ r_d) + K_ROUND3;
        endcase
        sum = r_a + fval + r_buf[msg_index(rnd, r_step[3:0])];
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
        mask = (32'h1 << {bc, 3'b000}) - 32'h1;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        n_ret   = r_ret;
        wr_en   = 1'b0;
        wr_data = '0;
        start   = 1'b0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_TAKE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    wr_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (!i_item.end_of_message) begin
                        wr_data = i_item.data_word;
                        n_len = r_len + 64'd32;
                        n_ret = ST_TAKE;
                    end else if (i_item.byte_count == FULL_COUNT) begin
                        wr_data = i_item.data_word;
                        n_len = r_len + 64'd32;
                        n_ret = ST_EXTRA;
                    end else begin
                        wr_data = (i_item.data_word & mask) | (PAD_WORD << {bc, 3'b000});
                        n_len = r_len + {59'd0, bc, 3'b000};
                        n_ret = ST_PAD;
                    end
                    if (r_idx == 4'd15) begin
                        start = 1'b1;
                        n_state = ST_COMP;
                    end else begin
                        n_state = n_ret;
                    end
                end
            end
            ST_EXTRA: begin
                wr_en = 1'b1;
                wr_data = PAD_WORD;
                n_idx = r_idx + 1'b1;
                n_ret = ST_PAD;
                if (r_idx == 4'd15) begin
                    start = 1'b1;
                    n_state = ST_COMP;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_idx == 4'd14) begin
                    n_state = ST_LEN_LO;
                end else begin
                    wr_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 4'd15) begin
                        start = 1'b1;
                        n_ret = ST_PAD;
                        n_state = ST_COMP;
                    end
                end
            end
            ST_LEN_LO: begin
                wr_en = 1'b1;
                wr_data = r_len[31:0];
                n_idx = r_idx + 1'b1;
                n_state = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                wr_en = 1'b1;
                wr_data = r_len[63:32];
                n_idx = '0;
                start = 1'b1;
                n_ret = ST_OUT;
                n_state = ST_COMP;
            end
            ST_COMP: begin
                if (r_step == 6'd48) begin
                    n_state = r_ret;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_TAKE;
                    n_len = '0;
                end
            end
            default: n_state = ST_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_idx   <= '0;
            r_len   <= '0;
            r_ret   <= ST_TAKE;
            r_step  <= '0;
            r_h[0]  <= IV0;
            r_h[1]  <= IV1;
            r_h[2]  <= IV2;
            r_h[3]  <= IV3;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_ret   <= n_ret;
            if (start) begin
                r_step <= '0;
            end else if (r_state == ST_COMP && r_step != 6'd48) begin
                r_step <= r_step + 1'b1;
            end
            if (r_state == ST_COMP && r_step == 6'd48) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
            end
            if (r_state == ST_OUT && i_ready) begin
                r_h[0] <= IV0;
                r_h[1] <= IV1;
                r_h[2] <= IV2;
                r_h[3] <= IV3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[r_idx] <= wr_data;
        if (start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
        end else if (r_state == ST_COMP && r_step != 6'd48) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= rot;
        end
    end

    assign o_digest_a = r_h[0];
    assign o_digest_b = r_h[1];
    assign o_digest_c = r_h[2];
    assign o_digest_d = r_h[3];
endmodule

/* rtl/md4_hash_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_hash_engine
// MD4 digest of a byte stream given as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_ready with i_data_word, i_byte_count and
// i_end_of_message; every word is full except the final one (1..4 bytes).
// Output channel: o_valid/i_ready with the four digest words, one transfer
// per message, after the final word.
// A four-entry queue holds incoming words while the core compresses. Each
// full block of sixteen words is taken one word per cycle while the queue
// has words, then compressed (one MD4 step per cycle in a single round
// unit); the core takes no new words until compression ends. After the
// final word come padding, the length words and one or two compressions.
// While the receiver stalls the digest is held and the core takes no words;
// the queue keeps accepting until full.
// Reset clears the queue, the length count and loads the MD4 initial values.
// ----------------------------------------------------------------------------
module md4_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);
    import md4_pkg::*;

    t_item in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.data_word      = i_data_word;
    assign in_item.byte_count     = i_byte_count;
    assign in_item.end_of_message = i_end_of_message;

    md4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    md4_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_item     (q_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_digest_a (o_digest_a),
        .o_digest_b (o_digest_b),
        .o_digest_c (o_digest_c),
        .o_digest_d (o_digest_d)
    );
endmodule
